// ===== hw/rtl/pidc_pkg.sv =====
// Shared types, constants and saturation helpers for the PID controller.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package pidc_pkg;

  localparam int unsigned DataW   = 32;  // Q16.16 word
  localparam int unsigned LimW    = 31;  // unsigned limits and dead band
  localparam int unsigned FracW   = 16;  // fraction bits
  localparam int unsigned CfgIdxW = 3;

  typedef logic signed [DataW-1:0] q_t;
  typedef logic        [LimW-1:0]  lim_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegGainP       = 3'd0,
    RegGainI       = 3'd1,
    RegGainD       = 3'd2,
    RegMaxIntegral = 3'd3,
    RegMaxOutput   = 3'd4,
    RegDeadBand    = 3'd5
  } cfg_reg_e;

  // Item commands
  typedef enum logic {
    CmdCalc  = 1'b0,
    CmdClear = 1'b1
  } cmd_e;

  // Saturate a 33-bit signed value to 32 bits
  function automatic q_t sat33(input logic signed [DataW:0] x);
    q_t res;
    if (x[DataW] != x[DataW-1]) begin
      res = x[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      res = x[DataW-1:0];
    end
    return res;
  endfunction

  // Clamp a 34-bit signed value to +-lim (lim is 31-bit unsigned)
  function automatic q_t clamp_sym(input logic signed [DataW+1:0] x, input lim_t lim);
    logic signed [DataW+1:0] pos;
    logic signed [DataW+1:0] neg;
    q_t                      res;
    pos = signed'({3'b000, lim});
    neg = -pos;
    if (x > pos) begin
      res = pos[DataW-1:0];
    end else if (x < neg) begin
      res = neg[DataW-1:0];
    end else begin
      res = x[DataW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pidc_if.sv =====
// Valid/ready stream interfaces for the PID controller input and result items.
// Depends on pidc_pkg for the payload types.
`default_nettype none

interface pidc_in_if;
  logic              valid;
  logic              ready;
  pidc_pkg::cmd_e    command;
  pidc_pkg::q_t      reference;
  pidc_pkg::q_t      feedback;

  modport source (output valid, output command, output reference, output feedback,
                  input ready);
  modport sink   (input valid, input command, input reference, input feedback,
                  output ready);
endinterface

interface pidc_out_if;
  logic              valid;
  logic              ready;
  pidc_pkg::q_t      drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pid_controller_deadzone_clamped.sv =====
// Positional PID controller with dead band, integral clamp and output clamp.
// Each item passes the input, error, product, accumulate and result registers in order.
// Throughput: one item per cycle; the five register stages advance together and
// freeze only while the result register holds an item that is not taken.
// Reset clears stage valid bits, configuration registers, error history and integral.
// Depends on pidc_pkg, pidc_if and pidc_qmul.
`default_nettype none

module pid_controller_deadzone_clamped (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pidc_in_if.sink                            in_i,
  pidc_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [pidc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pidc_pkg::DataW-1:0]         cfg_wdata_i
);

  localparam int unsigned W = pidc_pkg::DataW;

  // Configuration registers
  pidc_pkg::q_t   gain_p_q, gain_i_q, gain_d_q;
  pidc_pkg::lim_t max_int_q, max_out_q, dead_band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      max_int_q   <= '0;
      max_out_q   <= '0;
      dead_band_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pidc_pkg::cfg_reg_e'(cfg_idx_i))
        pidc_pkg::RegGainP:       gain_p_q    <= cfg_wdata_i;
        pidc_pkg::RegGainI:       gain_i_q    <= cfg_wdata_i;
        pidc_pkg::RegGainD:       gain_d_q    <= cfg_wdata_i;
        pidc_pkg::RegMaxIntegral: max_int_q   <= cfg_wdata_i[pidc_pkg::LimW-1:0];
        pidc_pkg::RegMaxOutput:   max_out_q   <= cfg_wdata_i[pidc_pkg::LimW-1:0];
        pidc_pkg::RegDeadBand:    dead_band_q <= cfg_wdata_i[pidc_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: all stages move unless the result register is stuck
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 0: input register
  logic           v0_q;
  pidc_pkg::cmd_e cmd0_q;
  pidc_pkg::q_t   ref0_q, fb0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_i.valid) begin
      cmd0_q <= in_i.command;
      ref0_q <= in_i.reference;
      fb0_q  <= in_i.feedback;
    end
  end

  // Stage 1: error, dead band, error difference against history
  pidc_pkg::q_t   prev_err_q;
  pidc_pkg::q_t   err_raw, err, diff;
  logic [W-1:0]   err_mag;

  always_comb begin
    err_raw = pidc_pkg::sat33({ref0_q[W-1], ref0_q} - {fb0_q[W-1], fb0_q});
    err_mag = err_raw[W-1] ? (~err_raw + 1'b1) : err_raw;
    err     = (err_mag < {1'b0, dead_band_q}) ? '0 : err_raw;
    diff    = pidc_pkg::sat33({err[W-1], err} - {prev_err_q[W-1], prev_err_q});
  end

  logic           v1_q;
  pidc_pkg::cmd_e cmd1_q;
  pidc_pkg::q_t   err1_q, diff1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      prev_err_q <= '0;
    end else if (adv) begin
      v1_q <= v0_q;
      if (v0_q) begin
        prev_err_q <= (cmd0_q == pidc_pkg::CmdClear) ? '0 : err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v0_q) begin
      cmd1_q  <= cmd0_q;
      err1_q  <= err;
      diff1_q <= diff;
    end
  end

  // Stage 2: the three gain products
  pidc_pkg::q_t p_prod, i_prod, d_prod;

  pidc_qmul u_mul_p (.a_i(err1_q),  .b_i(gain_p_q), .y_o(p_prod));
  pidc_qmul u_mul_i (.a_i(err1_q),  .b_i(gain_i_q), .y_o(i_prod));
  pidc_qmul u_mul_d (.a_i(diff1_q), .b_i(gain_d_q), .y_o(d_prod));

  logic           v2_q;
  pidc_pkg::cmd_e cmd2_q;
  pidc_pkg::q_t   p2_q, i2_q, d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      cmd2_q <= cmd1_q;
      p2_q   <= p_prod;
      i2_q   <= i_prod;
      d2_q   <= d_prod;
    end
  end

  // Stage 3: integral accumulate and clamp, partial sum of P and D
  pidc_pkg::q_t   integ_q, integ_d;
  logic signed [W:0] integ_sum;

  always_comb begin
    integ_sum = {integ_q[W-1], integ_q} + {i2_q[W-1], i2_q};
    if (cmd2_q == pidc_pkg::CmdClear) begin
      integ_d = '0;
    end else begin
      integ_d = pidc_pkg::clamp_sym({integ_sum[W], integ_sum}, max_int_q);
    end
  end

  logic              v3_q;
  pidc_pkg::cmd_e    cmd3_q;
  pidc_pkg::q_t      int3_q;
  logic signed [W:0] pd3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q    <= 1'b0;
      integ_q <= '0;
    end else if (adv) begin
      v3_q <= v2_q;
      if (v2_q) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      cmd3_q <= cmd2_q;
      int3_q <= integ_d;
      pd3_q  <= {d2_q[W-1], d2_q} + {p2_q[W-1], p2_q};
    end
  end

  // Stage 4: drive sum, output clamp, result register
  logic signed [W+1:0] drive_sum;
  pidc_pkg::q_t        drive, drive_q;

  always_comb begin
    drive_sum = {pd3_q[W], pd3_q} + {{2{int3_q[W-1]}}, int3_q};
    if (cmd3_q == pidc_pkg::CmdClear) begin
      drive = '0;
    end else begin
      drive = pidc_pkg::clamp_sym(drive_sum, max_out_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      drive_q <= drive;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.drive = drive_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pidc_qmul.sv =====
// Q16.16 multiply: exact 64-bit product, arithmetic shift by 16, saturate to 32 bits.
// Depends on pidc_pkg.
`default_nettype none

module pidc_qmul (
  input  pidc_pkg::q_t a_i,
  input  pidc_pkg::q_t b_i,
  output pidc_pkg::q_t y_o
);

  localparam int unsigned ProdW = 2 * pidc_pkg::DataW;
  localparam int unsigned TopLo = pidc_pkg::FracW + pidc_pkg::DataW - 1;

  logic signed [ProdW-1:0] prod;
  logic                    fits;

  // Operands sign-extended to the full product width
  assign prod = ProdW'(a_i) * ProdW'(b_i);

  // Shifted value fits when its sign bit and all bits above it agree
  assign fits = (&prod[ProdW-1:TopLo]) | ~(|prod[ProdW-1:TopLo]);

  always_comb begin
    if (fits) begin
      y_o = prod[TopLo:pidc_pkg::FracW];
    end else if (prod[ProdW-1]) begin
      y_o = {1'b1, {(pidc_pkg::DataW-1){1'b0}}};
    end else begin
      y_o = {1'b0, {(pidc_pkg::DataW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pidc_checker.sv =====
// Port-level checks for the PID controller, bound to the top level.
// Depends on pidc_pkg types through the bound top level ports.
`default_nettype none

module pidc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [pidc_pkg::DataW-1:0] out_drive_i
);

  // A pending result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // A pending result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_drive_i))
    else $error("result changed while stalled");

  // A stuck result blocks new input transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while result register is stuck");

  // A drained result register always lets input through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled with free result register");

  // No result in the cycle after a reset cycle
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid after reset");

endmodule

bind pid_controller_deadzone_clamped pidc_checker u_pidc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_drive_i (out_o.drive)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for pid_controller_deadzone_clamped: directed and random
// control steps, with a scoreboard that predicts each drive value.
// Depends on pidc_pkg, pidc_if and the controller RTL.
module testbench;

  localparam pidc_pkg::q_t QOne = 32'sh0001_0000;
  localparam pidc_pkg::q_t QMax = 32'sh7FFF_FFFF;
  localparam pidc_pkg::q_t QMin = 32'sh8000_0000;
  // Indexes past the last register; writes there must be dropped
  localparam logic [pidc_pkg::CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [pidc_pkg::CfgIdxW-1:0] RegSpare7 = 3'd7;

  // Predicts the drive of each step and matches it against the DUT
  class drive_scoreboard;
    longint       gain_p, gain_i, gain_d;
    longint       max_integral, max_output, dead_band;
    longint       last_error, integral;
    pidc_pkg::q_t expected_drives[$];
    int           errors;

    function new();
      gain_p = 0; gain_i = 0; gain_d = 0;
      max_integral = 0; max_output = 0; dead_band = 0;
      last_error = 0; integral = 0;
      errors = 0;
    endfunction

    function longint sat_word(longint x);
      if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return -64'sh8000_0000;
      return x;
    endfunction

    // Q16.16 multiply: exact product, floor shift, saturate
    function longint fx_mul(longint a, longint b);
      longint prod;
      prod = a * b;
      return sat_word(prod >>> 16);
    endfunction

    function longint clamp_mag(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
    endfunction

    function void set_reg(logic [pidc_pkg::CfgIdxW-1:0] idx,
                          logic [pidc_pkg::DataW-1:0] value);
      case (idx)
        pidc_pkg::RegGainP:       gain_p = longint'($signed(value));
        pidc_pkg::RegGainI:       gain_i = longint'($signed(value));
        pidc_pkg::RegGainD:       gain_d = longint'($signed(value));
        pidc_pkg::RegMaxIntegral:
          max_integral = longint'({1'b0, value[pidc_pkg::LimW-1:0]});
        pidc_pkg::RegMaxOutput:
          max_output = longint'({1'b0, value[pidc_pkg::LimW-1:0]});
        pidc_pkg::RegDeadBand:
          dead_band = longint'({1'b0, value[pidc_pkg::LimW-1:0]});
        default: ;
      endcase
    endfunction

    function void predict_drive(pidc_pkg::cmd_e cmd, pidc_pkg::q_t ref_v,
                                pidc_pkg::q_t fb_v);
      longint       err, mag, dterm, pterm, sum;
      pidc_pkg::q_t drive;
      if (cmd == pidc_pkg::CmdClear) begin
        last_error = 0;
        integral = 0;
        expected_drives.push_back('0);
        return;
      end
      err = sat_word(longint'(ref_v) - longint'(fb_v));
      mag = (err < 0) ? -err : err;
      if (mag < dead_band) err = 0;
      dterm = fx_mul(sat_word(err - last_error), gain_d);
      pterm = fx_mul(err, gain_p);
      integral = clamp_mag(integral + fx_mul(err, gain_i), max_integral);
      sum = clamp_mag(dterm + pterm + integral, max_output);
      last_error = err;
      drive = sum[31:0];
      expected_drives.push_back(drive);
    endfunction

    function void check_drive(pidc_pkg::q_t actual);
      pidc_pkg::q_t exp_v;
      if (expected_drives.size() == 0) begin
        errors++;
        $display("%0t: unexpected drive, expected none, got %0d", $time, actual);
        return;
      end
      exp_v = expected_drives.pop_front();
      if (actual !== exp_v) begin
        errors++;
        $display("%0t: drive mismatch, expected %0d, got %0d", $time, exp_v, actual);
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i;
  logic [pidc_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [pidc_pkg::DataW-1:0]     cfg_wdata_i;
  bit                             steady = 1'b0;     // no idling on either side
  bit                             stall_req = 1'b0;  // asks the receiver for a long hold-off

  drive_scoreboard sb = new();

  pidc_in_if  in_if();
  pidc_out_if out_if();

  pid_controller_deadzone_clamped uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch both channels; a transfer happens when valid and ready are high
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      sb.predict_drive(in_if.command, in_if.reference, in_if.feedback);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_drive(out_if.drive);
    end
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stall_req) begin
        out_if.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        stall_req = 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(pidc_pkg::cmd_e cmd, pidc_pkg::q_t ref_v, pidc_pkg::q_t fb_v);
    in_if.valid     <= 1'b1;
    in_if.command   <= cmd;
    in_if.reference <= ref_v;
    in_if.feedback  <= fb_v;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic idle_burst();
    in_if.valid <= 1'b0;
    repeat ($urandom_range(1, 9)) @(posedge clk_i);
  endtask

  // Wait until every drive has come back and the pipeline is empty;
  // a clock edge first so the monitor has counted the last transfer
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [pidc_pkg::CfgIdxW-1:0] idx,
                           logic [pidc_pkg::DataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic load_config(logic [pidc_pkg::DataW-1:0] gp, logic [pidc_pkg::DataW-1:0] gi,
                             logic [pidc_pkg::DataW-1:0] gd,
                             logic [pidc_pkg::DataW-1:0] max_int,
                             logic [pidc_pkg::DataW-1:0] max_out,
                             logic [pidc_pkg::DataW-1:0] band);
    write_reg(pidc_pkg::RegGainP, gp);
    write_reg(pidc_pkg::RegGainI, gi);
    write_reg(pidc_pkg::RegGainD, gd);
    write_reg(pidc_pkg::RegMaxIntegral, max_int);
    write_reg(pidc_pkg::RegMaxOutput, max_out);
    write_reg(pidc_pkg::RegDeadBand, band);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly moderate magnitudes, sometimes full range or an extreme
  function automatic pidc_pkg::q_t pick_value();
    pidc_pkg::q_t v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0: return v;
      1: begin
        case ($urandom_range(0, 3))
          0: return QMax;
          1: return QMin;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return v >>> $urandom_range(4, 15);
    endcase
  endfunction

  function automatic logic [pidc_pkg::DataW-1:0] rand_gain();
    pidc_pkg::q_t g;
    g = $urandom();
    case ($urandom_range(0, 7))
      0: return g;
      1: return $urandom_range(0, 1) ? QMax : QMin;
      default: return g >>> $urandom_range(10, 16);
    endcase
  endfunction

  function automatic logic [pidc_pkg::DataW-1:0] rand_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic logic [pidc_pkg::DataW-1:0] rand_band();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom();
      default: return $urandom_range(0, 32'h0002_0000);
    endcase
  endfunction

  // Random step; feedback often lands near the dead band around the reference
  task automatic random_item();
    pidc_pkg::cmd_e cmd;
    pidc_pkg::q_t   ref_v;
    pidc_pkg::q_t   fb_v;
    longint         span;
    longint         delta;
    cmd = ($urandom_range(0, 19) == 0) ? pidc_pkg::CmdClear : pidc_pkg::CmdCalc;
    ref_v = pick_value();
    if ($urandom_range(0, 2) == 0) begin
      span = (sb.dead_band > 64'sh100_0000) ? 64'sh100_0000 : sb.dead_band;
      delta = longint'($urandom_range(0, 2 * span)) - span;
      fb_v = ref_v - delta[31:0];
    end else begin
      fb_v = pick_value();
    end
    send_item(cmd, ref_v, fb_v);
  endtask

  initial begin
    in_if.valid     <= 1'b0;
    in_if.command   <= pidc_pkg::CmdCalc;
    in_if.reference <= '0;
    in_if.feedback  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= pidc_pkg::RegGainP;
    cfg_wdata_i     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config: zero output limit forces the drive to zero
    send_item(pidc_pkg::CmdCalc, 5 * QOne, QOne);
    send_item(pidc_pkg::CmdClear, QMax, QMin);
    settle();

    // Moderate gains, small clamps, dead band of 1.0
    write_reg(RegSpare6, '1);
    write_reg(RegSpare7, '1);
    load_config(QOne, QOne >>> 1, QOne >>> 2, 3 * QOne, 10 * QOne, QOne);
    send_item(pidc_pkg::CmdCalc, 2 * QOne, QOne + (QOne >>> 1));  // inside the dead band
    send_item(pidc_pkg::CmdCalc, 2 * QOne, QOne);                 // exactly on the band edge
    send_item(pidc_pkg::CmdCalc, '0, 3 * QOne);
    send_item(pidc_pkg::CmdCalc, 7 * QOne, '0);           // integral runs into its clamp
    send_item(pidc_pkg::CmdCalc, 7 * QOne, '0);
    send_item(pidc_pkg::CmdCalc, 7 * QOne, '0);
    send_item(pidc_pkg::CmdCalc, QMax, QMin);             // error saturates high
    send_item(pidc_pkg::CmdCalc, QMin, QMax);             // error saturates low
    send_item(pidc_pkg::CmdClear, 32'sh1234_5678, 32'sh8765_4321);
    send_item(pidc_pkg::CmdCalc, '1, '0);
    settle();

    // Extreme gains and limits; output limit written with bit 31 set
    load_config(QMax, QMin, QMin, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0);
    send_item(pidc_pkg::CmdCalc, QMax, QMin);
    send_item(pidc_pkg::CmdCalc, QMin, QMax);
    send_item(pidc_pkg::CmdCalc, '0, '0);
    send_item(pidc_pkg::CmdCalc, 32'sd1, '0);             // tiny products round down
    send_item(pidc_pkg::CmdCalc, '0, 32'sd1);
    send_item(pidc_pkg::CmdCalc, QMin, '0);
    send_item(pidc_pkg::CmdClear, '0, '0);
    settle();

    // Widest dead band, zero integral limit
    load_config(QOne, QOne, QOne, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(pidc_pkg::CmdCalc, QMax, '0);
    send_item(pidc_pkg::CmdCalc, QMin, '0);
    send_item(pidc_pkg::CmdCalc, 100 * QOne, '0);
    settle();

    // Random phases, each under a fresh configuration
    for (int phase = 0; phase < 7; phase++) begin
      load_config(rand_gain(), rand_gain(), rand_gain(),
                  rand_limit(), rand_limit(), rand_band());
      if (phase == 6) steady = 1'b1;
      for (int n = 0; n < 100; n++) begin
        if (phase == 1 && n == 10) stall_req = 1'b1;
        if (!steady && $urandom_range(0, 4) == 0) idle_burst();
        random_item();
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
